### sv/pcef_pkg.sv
// ----------------------------------------------------------------------------
// pcef_pkg
// shared types, register indexes and helpers of the patch extremum filter
// ----------------------------------------------------------------------------
package pcef_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 2048;
  localparam int unsigned DEF_MAX_HEIGHT = 4096;
  localparam int unsigned DEF_MAX_RADIUS = 15;

  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 13;
  localparam int unsigned WIDTH_BITS    = 12;
  localparam int unsigned HEIGHT_BITS   = 13;
  localparam int unsigned RADIUS_BITS   = 4;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 4'd7;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_WINDOW_RADIUS = 2'd2,
    CFG_EXTREMUM_MODE = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } item_cmd_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } in_item_t;

  typedef struct packed {
    logic [7:0] filtered_value;
    logic       end_of_row;
    logic       end_of_frame;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic scan_init;
    logic scan_step;
    logic emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic due;
    logic scan_last;
    logic out_free;
  } dp_status_t;

  function automatic logic [7:0] pick(input logic mode, input logic [7:0] a,
                                      input logic [7:0] b);
    if (mode) return (a > b) ? a : b;
    return (a < b) ? a : b;
  endfunction

endpackage

### sv/pcef_ctrl.sv
// ----------------------------------------------------------------------------
// pcef_ctrl
// sequencer: take a transaction, decide on a result, scan the window, emit
// ----------------------------------------------------------------------------
module pcef_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output pcef_pkg::dp_cmd_t   cmd_o,
  input  pcef_pkg::dp_status_t status_i
);
  import pcef_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   stall_q;
  logic   accept;

  assign accept     = in_valid_i && !stall_q;
  assign in_stall_o = stall_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.due) begin
          cmd_o.scan_init = 1'b1;
          state_d         = ST_SCAN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= (state_d != ST_IDLE);
    end
  end

`ifndef SYNTHESIS
  a_accept_then_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_CHECK) else $error("accept not followed by check");
  a_stall_outside_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> stall_q) else $error("input open while busy");
  a_emit_only_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> status_i.out_free) else $error("emit into full output");
`endif

endmodule

### sv/pcef_datapath.sv
// ----------------------------------------------------------------------------
// pcef_datapath
// config registers, frame counters, line store, window scan and output stage
// ----------------------------------------------------------------------------
module pcef_datapath #(
  parameter int unsigned MAX_WIDTH  = pcef_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = pcef_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned MAX_RADIUS = pcef_pkg::DEF_MAX_RADIUS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pcef_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [pcef_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  pcef_pkg::in_item_t                   in_data_i,
  input  pcef_pkg::dp_cmd_t                    cmd_i,
  output pcef_pkg::dp_status_t                 status_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output pcef_pkg::out_item_t                  out_data_o
);
  import pcef_pkg::*;

  localparam int unsigned CW        = $clog2(MAX_WIDTH);
  localparam int unsigned WW        = $clog2(MAX_WIDTH + 1);
  localparam int unsigned YW        = $clog2(MAX_HEIGHT);
  localparam int unsigned HW        = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RDW       = $clog2(MAX_RADIUS + 1);
  localparam int unsigned SLOTS_MAX = 2 * MAX_RADIUS + 2;
  localparam int unsigned SW        = $clog2(SLOTS_MAX);
  localparam int unsigned NW        = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int unsigned DEPTH     = SLOTS_MAX * MAX_WIDTH;
  localparam int unsigned AW        = $clog2(DEPTH);

  // configuration
  logic [WIDTH_BITS-1:0]  width_q;
  logic [HEIGHT_BITS-1:0] height_q;
  logic [RADIUS_BITS-1:0] radius_q;
  logic                   mode_q;
  logic                   restart_cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      radius_q <= RADIUS_RESET;
      mode_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:   width_q  <= cfg_data_i[WIDTH_BITS-1:0];
        CFG_IMAGE_HEIGHT:  height_q <= cfg_data_i[HEIGHT_BITS-1:0];
        CFG_WINDOW_RADIUS: radius_q <= cfg_data_i[RADIUS_BITS-1:0];
        CFG_EXTREMUM_MODE: mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end
  assign restart_cfg = cfg_we_i;

  // effective geometry
  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  logic [RDW-1:0] r_eff, rr, rc;
  logic [SW-1:0]  slots_m1;
  logic [NW-1:0]  lag;

  always_comb begin
    if (width_q == '0) w_eff = WW'(1);
    else if (32'(width_q) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(width_q);
    if (height_q == '0) h_eff = HW'(1);
    else if (32'(height_q) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(height_q);
    r_eff = (32'(radius_q) > MAX_RADIUS) ? RDW'(MAX_RADIUS) : RDW'(radius_q);
    rr = (32'(r_eff) > 32'(h_eff) - 1) ? RDW'(32'(h_eff) - 1) : r_eff;
    rc = (32'(r_eff) > 32'(w_eff) - 1) ? RDW'(32'(w_eff) - 1) : r_eff;
    slots_m1 = SW'(2 * 32'(rr) + 1);
    lag = NW'(32'(rr) * 32'(w_eff) + 32'(rc));
  end

  // frame counters
  logic [CW-1:0] in_col_q, out_col_q;
  logic [YW-1:0] in_row_q, out_row_q;
  logic [SW-1:0] in_slot_q, out_slot_q;
  logic [NW-1:0] rcv_cnt_q, out_cnt_q;
  logic          in_done_q;
  logic          pix_we;
  logic [7:0]    pix_val;
  logic          eor, eof;
  logic          restart;

  assign pix_we  = cmd_i.accept && (in_data_i.cmd == CMD_PIXEL) && !in_done_q;
  assign pix_val = pick(mode_q, pick(mode_q, in_data_i.blue, in_data_i.green),
                        in_data_i.red);
  assign eor     = (32'(out_col_q) == 32'(w_eff) - 1);
  assign eof     = eor && (32'(out_row_q) == 32'(h_eff) - 1);
  assign restart = restart_cfg || (cmd_i.emit && eof);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= '0;
      rcv_cnt_q  <= '0;
      in_done_q  <= 1'b0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_slot_q <= '0;
      out_cnt_q  <= '0;
    end else if (restart) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= '0;
      rcv_cnt_q  <= '0;
      in_done_q  <= 1'b0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_slot_q <= '0;
      out_cnt_q  <= '0;
    end else begin
      if (pix_we) begin
        rcv_cnt_q <= rcv_cnt_q + NW'(1);
        if (32'(in_col_q) == 32'(w_eff) - 1) begin
          in_col_q <= '0;
          if (32'(in_row_q) == 32'(h_eff) - 1) begin
            in_row_q  <= '0;
            in_slot_q <= '0;
            in_done_q <= 1'b1;
          end else begin
            in_row_q  <= in_row_q + YW'(1);
            in_slot_q <= (in_slot_q == slots_m1) ? '0 : in_slot_q + SW'(1);
          end
        end else begin
          in_col_q <= in_col_q + CW'(1);
        end
      end
      if (cmd_i.emit) begin
        out_cnt_q <= out_cnt_q + NW'(1);
        if (eor) begin
          out_col_q  <= '0;
          out_row_q  <= out_row_q + YW'(1);
          out_slot_q <= (out_slot_q == slots_m1) ? '0 : out_slot_q + SW'(1);
        end else begin
          out_col_q <= out_col_q + CW'(1);
        end
      end
    end
  end

  assign status_o.due = in_done_q || ((out_cnt_q + lag) < rcv_cnt_q);

  // window scan
  logic [CW-1:0]  sc_col_q, c0_q, c1_q;
  logic [SW-1:0]  sc_slot_q;
  logic [RDW:0]   rows_left_q;
  logic [RDW-1:0] kt, kb, kl, kr;
  logic [SW-1:0]  start_slot;

  always_comb begin
    kt = (32'(rr) > 32'(out_row_q)) ? RDW'(out_row_q) : rr;
    kb = (32'(rr) > 32'(h_eff) - 1 - 32'(out_row_q))
         ? RDW'(32'(h_eff) - 1 - 32'(out_row_q)) : rr;
    kl = (32'(rc) > 32'(out_col_q)) ? RDW'(out_col_q) : rc;
    kr = (32'(rc) > 32'(w_eff) - 1 - 32'(out_col_q))
         ? RDW'(32'(w_eff) - 1 - 32'(out_col_q)) : rc;
    if (32'(out_slot_q) >= 32'(kt)) start_slot = SW'(32'(out_slot_q) - 32'(kt));
    else start_slot = SW'(32'(out_slot_q) + 32'(slots_m1) + 1 - 32'(kt));
  end

  assign status_o.scan_last = (rows_left_q == '0) && (sc_col_q == c1_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      sc_slot_q   <= start_slot;
      sc_col_q    <= CW'(32'(out_col_q) - 32'(kl));
      c0_q        <= CW'(32'(out_col_q) - 32'(kl));
      c1_q        <= CW'(32'(out_col_q) + 32'(kr));
      rows_left_q <= (RDW+1)'(32'(kt) + 32'(kb));
    end else if (cmd_i.scan_step) begin
      if (sc_col_q == c1_q) begin
        sc_col_q    <= c0_q;
        sc_slot_q   <= (sc_slot_q == slots_m1) ? '0 : sc_slot_q + SW'(1);
        rows_left_q <= rows_left_q - (RDW+1)'(1);
      end else begin
        sc_col_q <= sc_col_q + CW'(1);
      end
    end
  end

  // line store
  logic [7:0]    mem_q [DEPTH];
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    rd_q;
  logic          rd_v_q;

  assign wr_addr = AW'(32'(in_slot_q) * MAX_WIDTH + 32'(in_col_q));
  assign rd_addr = AW'(32'(sc_slot_q) * MAX_WIDTH + 32'(sc_col_q));

  always_ff @(posedge clk_i) begin
    if (pix_we) mem_q[wr_addr] <= pix_val;
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_v_q <= 1'b0;
    else         rd_v_q <= cmd_i.scan_step;
  end

  logic [7:0] acc_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) acc_q <= mode_q ? 8'h00 : 8'hff;
    else if (rd_v_q)     acc_q <= pick(mode_q, acc_q, rd_q);
  end

  // output register
  logic      out_valid_q;
  out_item_t out_q;

  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.emit) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.filtered_value <= acc_q;
      out_q.end_of_row     <= eor;
      out_q.end_of_frame   <= eof;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_out_behind_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_cnt_q <= rcv_cnt_q) else $error("result count ahead of input count");
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(in_col_q) < 32'(w_eff)) else $error("input column beyond row width");
  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step |-> !pix_we) else $error("line store write during scan");
`endif

endmodule

### sv/patch_channel_extremum_filter_top.sv
// ----------------------------------------------------------------------------
// patch_channel_extremum_filter_top
// dark / bright channel of a clipped square patch over a raster pixel stream
// ----------------------------------------------------------------------------
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+------------------------------
//  in       | input     | in_valid/in_stall | cmd, blue, green, red
//  out      | output    | out_valid/stall   | filtered_value, eor, eof
//  cfg      | input     | cfg_valid/ready   | cfg_index, cfg_data
//
//  a transaction steps through accept and check; when a result is due it
//  then scans the clipped window, up to (2*MAX_RADIUS+1)^2 pixels, through
//  the one line store read port, then drains and finishes
//  reset clears counters and control and returns config to its defaults;
//  the line store is not cleared; out_stall only holds the finish step while
//  the output register is full; a config write restarts the frame and drops pending results
// ----------------------------------------------------------------------------
module patch_channel_extremum_filter_top #(
  parameter int unsigned MAX_WIDTH  = pcef_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = pcef_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned MAX_RADIUS = pcef_pkg::DEF_MAX_RADIUS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // pixel / drain transactions
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  pcef_pkg::in_item_t                 in_data_i,
  // result transactions
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output pcef_pkg::out_item_t                out_data_o,
  // register writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pcef_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [pcef_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);
  import pcef_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  pcef_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  pcef_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
